// File: sv/falru_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// falru_pkg: shared definitions for the fully associative LRU tag array
// Default parameter values, fixed payload widths and the control link type
// that runs along the chain of recency cells.
// ----------------------------------------------------------------------------
package falru_pkg;

   localparam int DEF_WAYS        = 8;
   localparam int DEF_OFFSET_BITS = 2;
   localparam int DEF_ADDR_WIDTH  = 32;

   localparam int ADDR_W    = 32;
   localparam int WAY_OUT_W = 3;
   localparam int COUNT_W   = 32;

   // Control link handed from one cell to the next.
   typedef struct packed {
      logic update;  // a lookup transaction is applied this cycle
      logic found;   // a valid matching entry sits ahead of this cell
   } cell_ctl_type;

endpackage

// File: sv/falru_req_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// falru_req_if: lookup request channel
// Carries one byte address per transaction with a valid/ready handshake.
// ----------------------------------------------------------------------------
interface falru_req_if;
   import falru_pkg::*;

   logic              valid;
   logic              ready;
   logic [ADDR_W-1:0] address;

   modport source (output valid, output address, input ready);
   modport sink   (input valid, input address, output ready);

endinterface

// File: sv/falru_rsp_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// falru_rsp_if: lookup response channel
// Carries hit flag, way used and the running hit and access counts.
// ----------------------------------------------------------------------------
interface falru_rsp_if;
   import falru_pkg::*;

   logic                 valid;
   logic                 ready;
   logic                 hit;
   logic [WAY_OUT_W-1:0] way;
   logic [COUNT_W-1:0]   hit_count;
   logic [COUNT_W-1:0]   access_count;

   modport source (output valid, output hit, output way, output hit_count,
                   output access_count, input ready);
   modport sink   (input valid, input hit, input way, input hit_count,
                   input access_count, output ready);

endinterface

// File: sv/fully_assoc_lru_cache_tags.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fully_assoc_lru_cache_tags: tag array of a fully associative LRU cache
// A row of recency cells, front (most recent) to back, with hit counting.
// ----------------------------------------------------------------------------
// Usage:
// The req_chan channel takes one byte address per transaction; the low
// OFFSET_BITS bits are ignored and the rest form the tag. Each request
// yields exactly one transaction on rsp_chan with the hit flag, the way
// hit or filled, and wrapping 32-bit hit and access counts that include
// this access.
// The response is registered and shows on the cycle after the request
// is taken. One request is taken per cycle while the receiver takes each
// response; the lookup, the promotion of the entry to the front and the
// shift of the cells behind it all complete in the cycle of acceptance,
// set by the match chain that runs through all WAYS cells.
// When the receiver stalls, the response register holds its transaction
// and req_chan.ready stays low until the response is taken; a request is
// accepted in the same cycle the waiting response leaves.
// Reset clears all valid bits and both counters and sets the recency list
// to ways WAYS-1 down to 0, front first; no clearing pass is needed.
// ----------------------------------------------------------------------------
module fully_assoc_lru_cache_tags #(
   parameter int WAYS        = falru_pkg::DEF_WAYS,
   parameter int OFFSET_BITS = falru_pkg::DEF_OFFSET_BITS,
   parameter int ADDR_WIDTH  = falru_pkg::DEF_ADDR_WIDTH
) (
   input logic         clock,
   input logic         reset,
   falru_req_if.sink   req_chan,
   falru_rsp_if.source rsp_chan
);
   import falru_pkg::*;

   localparam int EFF_ADDR_W = (ADDR_WIDTH < ADDR_W) ? ADDR_WIDTH : ADDR_W;
   localparam int TAG_W      = EFF_ADDR_W - OFFSET_BITS;
   localparam int WAY_W      = (WAYS > 1) ? $clog2(WAYS) : 1;

   logic                 accept;
   logic [TAG_W-1:0]     lookup_tag;
   cell_ctl_type         ctl_chain [WAYS+1];
   logic [WAYS-1:0]      match_vec;
   logic [WAY_W-1:0]     cell_way  [WAYS];
   logic [TAG_W-1:0]     cell_tag  [WAYS];
   logic                 cell_valid[WAYS];
   logic [WAY_W-1:0]     prev_way  [WAYS];
   logic [TAG_W-1:0]     prev_tag  [WAYS];
   logic                 prev_valid[WAYS];
   logic                 hit;
   logic [WAY_W-1:0]     hit_way;
   logic [WAY_W-1:0]     sel_way;
   logic [31:0]          sel_way_wide;

   logic                 rsp_valid_ff, rsp_valid_in;
   logic                 rsp_hit_ff;
   logic [WAY_OUT_W-1:0] rsp_way_ff;
   logic [COUNT_W-1:0]   hits_ff, hits_in;
   logic [COUNT_W-1:0]   accesses_ff, accesses_in;

   assign req_chan.ready = !rsp_valid_ff || rsp_chan.ready;
   assign accept         = req_chan.valid && req_chan.ready;
   assign lookup_tag     = TAG_W'(req_chan.address >> OFFSET_BITS);

   assign ctl_chain[0].update = accept;
   assign ctl_chain[0].found  = 1'b0;

   // The front cell takes the promoted entry: the matching way on a hit,
   // or on a miss the back way refilled with the new tag.
   always_comb begin
      hit_way = '0;
      for (int i = 0; i < WAYS; i++) begin
         hit_way = hit_way | (match_vec[i] ? cell_way[i] : '0);
      end
   end

   assign hit     = ctl_chain[WAYS].found;
   assign sel_way = hit ? hit_way : cell_way[WAYS-1];

   genvar g;
   generate
      for (g = 0; g < WAYS; g++) begin : g_cell
         if (g == 0) begin : g_front
            assign prev_way[g]   = sel_way;
            assign prev_tag[g]   = lookup_tag;
            assign prev_valid[g] = 1'b1;
         end else begin : g_rest
            assign prev_way[g]   = cell_way[g-1];
            assign prev_tag[g]   = cell_tag[g-1];
            assign prev_valid[g] = cell_valid[g-1];
         end

         falru_cell #(
            .TAG_W     (TAG_W),
            .WAY_W     (WAY_W),
            .RESET_WAY (WAYS - 1 - g)
         ) u_cell (
            .clock      (clock),
            .reset      (reset),
            .ctl_in     (ctl_chain[g]),
            .ctl_out    (ctl_chain[g+1]),
            .lookup_tag (lookup_tag),
            .prev_way   (prev_way[g]),
            .prev_tag   (prev_tag[g]),
            .prev_valid (prev_valid[g]),
            .match      (match_vec[g]),
            .way_q      (cell_way[g]),
            .tag_q      (cell_tag[g]),
            .valid_q    (cell_valid[g])
         );
      end
   endgenerate

   assign sel_way_wide = 32'(sel_way);
   assign hits_in      = (accept && hit) ? hits_ff + COUNT_W'(1) : hits_ff;
   assign accesses_in  = accept ? accesses_ff + COUNT_W'(1) : accesses_ff;
   assign rsp_valid_in = accept || (rsp_valid_ff && !rsp_chan.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         hits_ff      <= '0;
         accesses_ff  <= '0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         hits_ff      <= hits_in;
         accesses_ff  <= accesses_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_hit_ff <= hit;
         rsp_way_ff <= sel_way_wide[WAY_OUT_W-1:0];
      end
   end

   assign rsp_chan.valid        = rsp_valid_ff;
   assign rsp_chan.hit          = rsp_hit_ff;
   assign rsp_chan.way          = rsp_way_ff;
   assign rsp_chan.hit_count    = hits_ff;
   assign rsp_chan.access_count = accesses_ff;

`ifndef SYNTH
   // A way is written only on a miss, so no two cells can match at once.
   a_single_match: assert property (@(posedge clock) disable iff (reset)
      $onehot0(match_vec))
      else $error("more than one cell matched the lookup tag");

   a_rsp_follows: assert property (@(posedge clock) disable iff (reset)
      accept |=> rsp_valid_ff)
      else $error("accepted request produced no response");

   a_access_step: assert property (@(posedge clock) disable iff (reset)
      (accept && !reset) |=> (accesses_ff == $past(accesses_ff) + COUNT_W'(1)))
      else $error("access count did not advance by one");

   a_hit_step: assert property (@(posedge clock) disable iff (reset)
      (accept && !hit && !reset) |=> (hits_ff == $past(hits_ff)))
      else $error("hit count moved on a miss");
`endif

endmodule

// File: sv/falru_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// falru_cell: one position of the recency list
// Holds a way number with its tag and valid bit, compares the lookup tag
// and takes its neighbor's entry when the list shifts past it.
// ----------------------------------------------------------------------------
module falru_cell #(
   parameter int TAG_W     = 30,
   parameter int WAY_W     = 3,
   parameter int RESET_WAY = 0
) (
   input  logic                    clock,
   input  logic                    reset,
   input  falru_pkg::cell_ctl_type ctl_in,
   output falru_pkg::cell_ctl_type ctl_out,
   input  logic [TAG_W-1:0]        lookup_tag,
   input  logic [WAY_W-1:0]        prev_way,
   input  logic [TAG_W-1:0]        prev_tag,
   input  logic                    prev_valid,
   output logic                    match,
   output logic [WAY_W-1:0]        way_q,
   output logic [TAG_W-1:0]        tag_q,
   output logic                    valid_q
);
   import falru_pkg::*;

   logic [WAY_W-1:0] way_ff, way_in;
   logic [TAG_W-1:0] tag_ff, tag_in;
   logic             valid_ff, valid_in;
   logic             shift;

   assign match = valid_ff && (tag_ff == lookup_tag);

   // The cell moves back by one unless the entry being promoted lies ahead.
   assign shift = ctl_in.update && !ctl_in.found;

   assign ctl_out.update = ctl_in.update;
   assign ctl_out.found  = ctl_in.found || match;

   assign way_in   = shift ? prev_way   : way_ff;
   assign tag_in   = shift ? prev_tag   : tag_ff;
   assign valid_in = shift ? prev_valid : valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         way_ff   <= WAY_W'(RESET_WAY);
         valid_ff <= 1'b0;
      end else begin
         way_ff   <= way_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      tag_ff <= tag_in;
   end

   assign way_q   = way_ff;
   assign tag_q   = tag_ff;
   assign valid_q = valid_ff;

endmodule

// File: tb/fully_assoc_lru_cache_tags_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fully_assoc_lru_cache_tags_tb: self-checking bench for the LRU tag array
// Runs a short table of directed lookups, then phases of random lookups drawn
// mostly from small working sets so that hits, LRU evictions and refills all
// occur. Every response is compared with a bench-side model of the tags, the
// recency list and the counters, with random idles on both channels.
// ----------------------------------------------------------------------------
module fully_assoc_lru_cache_tags_tb;
   import falru_pkg::*;

   localparam int WAYS            = DEF_WAYS;
   localparam int OFFSET_BITS     = DEF_OFFSET_BITS;
   localparam int TAG_W           = ADDR_W - OFFSET_BITS;
   localparam int NUM_PHASES      = 5;
   localparam int ITEMS_PER_PHASE = 240;
   localparam int DRAIN_CYCLES    = 6;
   localparam int CYCLE_LIMIT     = 600000;
   localparam int MAX_REPORTS     = 100;

   typedef struct packed {
      logic                 hit;
      logic [WAY_OUT_W-1:0] way;
      logic [COUNT_W-1:0]   hit_count;
      logic [COUNT_W-1:0]   access_count;
   } lookup_result_type;

   // One lookup to send; when fixed is set, result is the typed-in answer.
   typedef struct {
      logic [ADDR_W-1:0] address;
      bit                fixed;
      lookup_result_type result;
   } lookup_row_type;

   logic clock = 1'b0;
   logic reset;

   falru_req_if req_bus ();
   falru_rsp_if rsp_bus ();

   fully_assoc_lru_cache_tags dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_bus),
      .rsp_chan (rsp_bus)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Bench copy of the tag array, recency list and counters.
   logic [TAG_W-1:0]   tag_store [WAYS];
   bit                 tag_valid [WAYS];
   int                 lru_order [WAYS];
   logic [COUNT_W-1:0] hit_tally;
   logic [COUNT_W-1:0] access_tally;

   lookup_result_type  expected_lookups [$];
   lookup_row_type     sent_rows [$];
   lookup_row_type     directed_rows [$];
   logic [TAG_W-1:0]   hot_tags [16];

   int  mismatches = 0;
   int  responses_checked = 0;
   int  cycle_count = 0;
   bit  rsp_stalls_on = 1'b0;

   function automatic lookup_result_type predict_lookup(input logic [ADDR_W-1:0] address);
      logic [TAG_W-1:0]  tag;
      int                w;
      int                pos;
      bit                found;
      lookup_result_type res;
      tag   = address[ADDR_W-1:OFFSET_BITS];
      found = 1'b0;
      w     = 0;
      access_tally = access_tally + COUNT_W'(1);
      for (int i = 0; i < WAYS; i++) begin
         if (!found && tag_valid[i] && tag_store[i] == tag) begin
            found = 1'b1;
            w     = i;
         end
      end
      if (found) begin
         hit_tally = hit_tally + COUNT_W'(1);
      end else begin
         // The way at the back of the recency list is the victim.
         w            = lru_order[WAYS-1] % WAYS;
         tag_store[w] = tag;
         tag_valid[w] = 1'b1;
      end
      pos = WAYS - 1;
      for (int i = WAYS - 1; i >= 0; i--) begin
         if (lru_order[i] == w) pos = i;
      end
      for (int i = pos; i > 0; i--) begin
         lru_order[i] = lru_order[i-1];
      end
      lru_order[0]     = w;
      res.hit          = found;
      res.way          = WAY_OUT_W'(w);
      res.hit_count    = hit_tally;
      res.access_count = access_tally;
      return res;
   endfunction

   function automatic int gap_length();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 55) return 0;
      if (roll < 85) return $urandom_range(1, 3);
      if (roll < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   task automatic add_row(input logic [ADDR_W-1:0] address, input bit fixed,
                          input logic hit, input int way, input int hits, input int count);
      lookup_row_type row;
      row.address             = address;
      row.fixed               = fixed;
      row.result.hit          = hit;
      row.result.way          = WAY_OUT_W'(way);
      row.result.hit_count    = COUNT_W'(hits);
      row.result.access_count = COUNT_W'(count);
      directed_rows.push_back(row);
   endtask

   task automatic send_lookup(input lookup_row_type row);
      sent_rows.push_back(row);
      req_bus.valid   <= 1'b1;
      req_bus.address <= row.address;
      do @(posedge clock); while (req_bus.ready !== 1'b1);
   endtask

   task automatic hold_off(input int cycles);
      if (cycles > 0) begin
         req_bus.valid   <= 1'b0;
         req_bus.address <= $urandom;
         repeat (cycles) @(posedge clock);
      end
   endtask

   task automatic note_mismatch(input string field, input logic [COUNT_W-1:0] want,
                                input logic [COUNT_W-1:0] got);
      mismatches++;
      if (mismatches <= MAX_REPORTS)
         $display("%0t: %s expected %0h, got %0h", $time, field, want, got);
   endtask

   // Receiver: runs of ready broken by stalls of random length when enabled.
   initial begin
      forever begin
         if (!rsp_stalls_on) begin
            rsp_bus.ready <= 1'b1;
            @(posedge clock);
         end else begin
            rsp_bus.ready <= 1'b1;
            repeat (gap_length() + 1) @(posedge clock);
            rsp_bus.ready <= 1'b0;
            repeat (gap_length() + 1) @(posedge clock);
         end
      end
   end

   // Both channels are sampled at the clock edge, before any update lands.
   always @(posedge clock) begin : watch_channels
      lookup_result_type predicted;
      lookup_result_type want;
      lookup_row_type    row;
      if (!reset) begin
         if (req_bus.valid === 1'b1 && req_bus.ready === 1'b1) begin
            predicted = predict_lookup(req_bus.address);
            if (sent_rows.size() != 0) begin
               row = sent_rows.pop_front();
               expected_lookups.push_back(row.fixed ? row.result : predicted);
            end else begin
               expected_lookups.push_back(predicted);
            end
         end
         if (rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1) begin
            if (expected_lookups.size() == 0) begin
               mismatches++;
               if (mismatches <= MAX_REPORTS)
                  $display("%0t: response with none expected (hit %0b way %0d)",
                           $time, rsp_bus.hit, rsp_bus.way);
            end else begin
               want = expected_lookups.pop_front();
               responses_checked++;
               if (rsp_bus.hit !== want.hit)
                  note_mismatch("hit", COUNT_W'(want.hit), COUNT_W'(rsp_bus.hit));
               if (rsp_bus.way !== want.way)
                  note_mismatch("way", COUNT_W'(want.way), COUNT_W'(rsp_bus.way));
               if (rsp_bus.hit_count !== want.hit_count)
                  note_mismatch("hit_count", want.hit_count, rsp_bus.hit_count);
               if (rsp_bus.access_count !== want.access_count)
                  note_mismatch("access_count", want.access_count, rsp_bus.access_count);
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("%0t: timed out with %0d responses outstanding", $time,
                  expected_lookups.size());
         $display("fully_assoc_lru_cache_tags: mismatch");
         $finish;
      end
   end

   initial begin
      lookup_row_type   row;
      logic [TAG_W-1:0] tag;
      logic [TAG_W-1:0] last_tag;
      int               pool;
      int               roll;
      bit               sender_gaps;

      reset           <= 1'b1;
      req_bus.valid   <= 1'b0;
      req_bus.address <= '0;
      for (int i = 0; i < WAYS; i++) begin
         tag_store[i] = '0;
         tag_valid[i] = 1'b0;
         lru_order[i] = WAYS - 1 - i;
      end
      hit_tally    = '0;
      access_tally = '0;
      last_tag     = '0;

      // From reset the back of the list is way 0, then ways 1 to 7 fill in order.
      add_row(32'h0000_0000, 1, 1'b0, 0, 0, 1);
      add_row(32'h0000_0003, 1, 1'b1, 0, 1, 2);   // offset bits are ignored
      add_row(32'hFFFF_FFFF, 1, 1'b0, 1, 1, 3);
      add_row(32'hFFFF_FFFC, 1, 1'b1, 1, 2, 4);
      add_row(32'h0000_0004, 1, 1'b0, 2, 2, 5);
      add_row(32'h0000_0008, 1, 1'b0, 3, 2, 6);
      add_row(32'h0000_000C, 1, 1'b0, 4, 2, 7);
      add_row(32'h0000_0010, 1, 1'b0, 5, 2, 8);
      add_row(32'h0000_0014, 1, 1'b0, 6, 2, 9);
      add_row(32'h0000_0018, 1, 1'b0, 7, 2, 10);
      // The set is full: these evict, re-miss on evicted tags and hit mid-list.
      add_row(32'h0000_0020, 0, 1'b0, 0, 0, 0);
      add_row(32'h0000_0000, 0, 1'b0, 0, 0, 0);
      add_row(32'h0000_0012, 0, 1'b0, 0, 0, 0);
      add_row(32'h0000_0019, 0, 1'b0, 0, 0, 0);
      add_row(32'h0000_001A, 0, 1'b0, 0, 0, 0);
      add_row(32'hAAAA_AAAA, 0, 1'b0, 0, 0, 0);
      add_row(32'h5555_5555, 0, 1'b0, 0, 0, 0);
      add_row(32'h8000_0000, 0, 1'b0, 0, 0, 0);
      add_row(32'h7FFF_FFFF, 0, 1'b0, 0, 0, 0);
      add_row(32'hAAAA_AAA9, 0, 1'b0, 0, 0, 0);
      add_row(32'hFFFF_FFFE, 0, 1'b0, 0, 0, 0);
      add_row(32'h0000_0024, 0, 1'b0, 0, 0, 0);
      add_row(32'h0000_0004, 0, 1'b0, 0, 0, 0);

      repeat (8) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i]) send_lookup(directed_rows[i]);

      for (int phase = 0; phase < NUM_PHASES; phase++) begin
         // Drain completely before the working set and idling pattern change.
         hold_off(1);
         while (expected_lookups.size() != 0 || sent_rows.size() != 0) @(posedge clock);
         case (phase)
            0:       pool = 3;
            1:       pool = 8;
            2:       pool = 9;
            3:       pool = 12;
            default: pool = 16;
         endcase
         sender_gaps   = (phase != 0);
         rsp_stalls_on = (phase != 0 && phase != 2);
         for (int i = 0; i < 16; i++) hot_tags[i] = TAG_W'($urandom);

         for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
            roll = $urandom_range(0, 99);
            if (roll < 70)
               tag = hot_tags[$urandom_range(0, pool - 1)];
            else if (roll < 85)
               tag = last_tag;
            else
               tag = TAG_W'($urandom);
            last_tag    = tag;
            row.address = {tag, OFFSET_BITS'($urandom)};
            row.fixed   = 1'b0;
            row.result  = '0;
            send_lookup(row);
            hold_off(sender_gaps ? gap_length() : 0);
         end
      end

      hold_off(1);
      while (expected_lookups.size() != 0 || sent_rows.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Checked %0d responses: %0d hits and %0d misses over %0d random phases,",
               responses_checked, hit_tally, access_tally - hit_tally, NUM_PHASES);
      $display("working sets of 3 to 16 tags, with idles and stalls on both channels.");
      if (mismatches == 0) begin
         $display("fully_assoc_lru_cache_tags: match");
      end else begin
         $display("fully_assoc_lru_cache_tags: mismatch");
      end
      $finish;
   end

endmodule
